FILE: design/pve_pkg.sv
// ----------------------------------------------------------------------------
// pve_pkg: shared types and constants
// Register map codes, payload widths and the control state encoding.
// ----------------------------------------------------------------------------
package pve_pkg;

	localparam int TimeW  = 32;
	localparam int PosW   = 20;
	localparam int VelW   = 32;
	localparam int UnitsW = 16;
	localparam int MaxVW  = 31;
	localparam int WinW   = 16;
	localparam int CountW = 4;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_UNITS  = 2'd0;
	localparam logic [1:0] REG_MAXVEL = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;

	localparam logic [UnitsW-1:0] UnitsReset  = 16'd1000;
	localparam logic [WinW-1:0]   WindowReset = 16'd100;

	// product magnitude: 21-bit delta times 16-bit units
	localparam int ProdW = 38;
	localparam int MagW  = 37;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_RD     = 9'b000000010,
		ST_CMP    = 9'b000000100,
		ST_OLD_RD = 9'b000001000,
		ST_OLD    = 9'b000010000,
		ST_DIVGO  = 9'b000100000,
		ST_DIV    = 9'b001000000,
		ST_SAT    = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

endpackage

FILE: design/pve_ram.sv
// ----------------------------------------------------------------------------
// pve_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pve_ram #(
	parameter int Width = 72,
	parameter int Depth = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/pve_div.sv
// ----------------------------------------------------------------------------
// pve_div: unsigned restoring divider
// One quotient bit per cycle; NumW quotient bits per division.
// ----------------------------------------------------------------------------
module pve_div #(
	parameter int NumW = 37,
	parameter int DenW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NumW-1:0] dividend,
	input  logic [DenW-1:0] divisor,
	output logic            busy,
	output logic [NumW-1:0] quotient
);

	localparam int CntW = $clog2(NumW + 1);

	logic            busy_q;
	logic [CntW-1:0] cnt_q;
	logic [DenW:0]   rem_q;
	logic [NumW-1:0] quo_q;
	logic [DenW-1:0] den_q;
	logic [DenW:0]   shifted;
	logic            fits;

	assign shifted = {rem_q[DenW-1:0], quo_q[NumW-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(NumW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? shifted - {1'b0, den_q} : shifted;
			quo_q <= {quo_q[NumW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

FILE: design/pointer_velocity_estimator_top.sv
// ----------------------------------------------------------------------------
// pointer_velocity_estimator_top: windowed two-point pointer velocity
// Keeps a ring of recent samples in RAM and reports x/y velocity per sample.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------------------
//  s_*      | in  | tdata: timestamp_ms, x_pos, y_pos; tuser: is_down
//  m_*      | out | tdata: x_velocity, y_velocity; tuser: count, valid
//  APB p*   | in  | velocity_units @0x0, max_velocity @0x4, window_ms @0x8
//
//  Order: with fewer than two held, acceptance goes straight to ST_DONE; else
//  each entry scanned is read (ST_RD) and compared (ST_CMP), ST_OLD_RD reads
//  the old entry, ST_OLD multiplies, ST_DIVGO starts and ST_DIV awaits the
//  dividers, ST_SAT saturates, ST_DONE loads, and s_tready returns in ST_IDLE.
//  Reset: state, pointers, fill, m_tvalid, config; RAM read only once written.
//  Stalls: a held result does not block the next request, only its own load.
//
module pointer_velocity_estimator_top #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // [31:0] timestamp_ms, [51:32] x_pos, [71:52] y_pos
	input  logic        s_tuser,   // [0] is_down
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] x_velocity, [63:32] y_velocity
	output logic [4:0]  m_tuser,   // [3:0] history_count, [4] velocity_valid
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FW = $clog2(HISTORY_DEPTH + 1);
	localparam int TW = pve_pkg::TimeW;
	localparam int PW = pve_pkg::PosW;
	localparam int EW = TW + 2 * PW;

	// ---------------- configuration registers ----------------
	logic [pve_pkg::UnitsW-1:0] units_q;
	logic [pve_pkg::MaxVW-1:0]  maxv_q;
	logic [pve_pkg::WinW-1:0]   window_q;
	logic                       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units_q  <= pve_pkg::UnitsReset;
			maxv_q   <= '0;
			window_q <= pve_pkg::WindowReset;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				pve_pkg::REG_UNITS:  units_q  <= pwdata[pve_pkg::UnitsW-1:0];
				pve_pkg::REG_MAXVEL: maxv_q   <= pwdata[pve_pkg::MaxVW-1:0];
				pve_pkg::REG_WINDOW: window_q <= pwdata[pve_pkg::WinW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pve_pkg::REG_UNITS:  prdata = 32'(units_q);
			pve_pkg::REG_MAXVEL: prdata = 32'(maxv_q);
			pve_pkg::REG_WINDOW: prdata = 32'(window_q);
			default:             prdata = '0;
		endcase
	end

	// ---------------- control state ----------------
	pve_pkg::state_t state_q;
	logic [IW-1:0]   head_q;
	logic [FW-1:0]   fill_q;
	logic [IW-1:0]   base_q;    // slot of the oldest held sample
	logic [FW-1:0]   i_q;       // scan position, newest = fill-1
	logic [FW-1:0]   start_q;
	logic            s_acc;

	// newest sample, kept in registers
	logic [TW-1:0] t_q;
	logic [PW-1:0] x_q, y_q;

	assign s_tready = (state_q == pve_pkg::ST_IDLE);
	assign s_acc    = s_tvalid & s_tready;

	// ring slot of history position k
	function automatic logic [IW-1:0] slot_f(input logic [IW-1:0] b,
	                                         input logic [FW-1:0] k);
		logic [FW:0] s;
		s = (FW+1)'(b) + (FW+1)'(k);
		if (s >= (FW+1)'(HISTORY_DEPTH)) begin
			s = s - (FW+1)'(HISTORY_DEPTH);
		end
		return s[IW-1:0];
	endfunction

	// pointer update for an accepted request
	logic [IW-1:0] head_eff, head_new;
	logic [FW-1:0] fill_eff, fill_new;
	logic [FW:0]   base_wide;

	always_comb begin
		head_eff = s_tuser ? '0 : head_q;
		fill_eff = s_tuser ? '0 : fill_q;
		head_new = (head_eff == IW'(HISTORY_DEPTH - 1)) ? '0 : head_eff + 1'b1;
		fill_new = (fill_eff < FW'(HISTORY_DEPTH)) ? fill_eff + 1'b1 : fill_eff;
		if ((FW+1)'(head_new) >= (FW+1)'(fill_new)) begin
			base_wide = (FW+1)'(head_new) - (FW+1)'(fill_new);
		end else begin
			base_wide = (FW+1)'(head_new) + (FW+1)'(HISTORY_DEPTH) - (FW+1)'(fill_new);
		end
	end

	// ---------------- history RAM ----------------
	logic          ram_re;
	logic [IW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	logic [TW-1:0] rd_t;
	logic [PW-1:0] rd_x, rd_y;
	logic [FW-1:0] old_pos;

	assign old_pos = (start_q > fill_q - FW'(2)) ? fill_q - FW'(2) : start_q;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = slot_f(base_q, old_pos);
		if (state_q == pve_pkg::ST_RD) begin
			ram_re    = 1'b1;
			ram_raddr = slot_f(base_q, i_q - 1'b1);
		end else if (state_q == pve_pkg::ST_OLD_RD) begin
			ram_re = 1'b1;
		end
	end

	pve_ram #(
		.Width(EW),
		.Depth(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (s_acc),
		.waddr(head_eff),
		.wdata(s_tdata[EW-1:0]),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_t = ram_rdata[TW-1:0];
	assign rd_x = ram_rdata[TW+PW-1:TW];
	assign rd_y = ram_rdata[EW-1:TW+PW];

	// ---------------- arithmetic ----------------
	logic [TW-1:0] age;
	logic [TW-1:0] dur_q;
	logic signed [pve_pkg::ProdW-1:0] px_s1, py_s1;
	logic signed [PW:0]  dx, dy;
	logic [pve_pkg::MagW-1:0] mx, my, qx, qy;
	logic                     busy_x, busy_y;
	logic                     div_go;

	assign age    = t_q - rd_t;
	assign dx     = (PW+1)'(signed'(x_q)) - (PW+1)'(signed'(rd_x));
	assign dy     = (PW+1)'(signed'(y_q)) - (PW+1)'(signed'(rd_y));
	assign div_go = (state_q == pve_pkg::ST_DIVGO);

	function automatic logic [pve_pkg::MagW-1:0] mag_f(
		input logic signed [pve_pkg::ProdW-1:0] p);
		logic [pve_pkg::ProdW-1:0] a;
		a = p[pve_pkg::ProdW-1] ? -p : p;
		return a[pve_pkg::MagW-1:0];
	endfunction

	assign mx = mag_f(px_s1);
	assign my = mag_f(py_s1);

	pve_div #(.NumW(pve_pkg::MagW), .DenW(TW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_go),
		.dividend(mx), .divisor(dur_q), .busy(busy_x), .quotient(qx)
	);

	pve_div #(.NumW(pve_pkg::MagW), .DenW(TW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_go),
		.dividend(my), .divisor(dur_q), .busy(busy_y), .quotient(qy)
	);

	// clamp to max_velocity when set, else saturate to the 32-bit signed range
	function automatic logic [pve_pkg::VelW-1:0] sat_f(
		input logic                      neg,
		input logic [pve_pkg::MagW-1:0]  q,
		input logic [pve_pkg::MaxVW-1:0] maxv);
		logic [pve_pkg::MagW-1:0] lim;
		logic [pve_pkg::MagW-1:0] m;
		if (maxv != '0) begin
			lim = pve_pkg::MagW'(maxv);
		end else if (neg) begin
			lim = pve_pkg::MagW'(33'h0_8000_0000);
		end else begin
			lim = pve_pkg::MagW'(33'h0_7FFF_FFFF);
		end
		m = (q > lim) ? lim : q;
		return neg ? -m[pve_pkg::VelW-1:0] : m[pve_pkg::VelW-1:0];
	endfunction

	logic [pve_pkg::VelW-1:0] vx_q, vy_q;
	logic                     vvalid_q;
	logic                     out_load;

	// in ST_DONE, the result register loads when empty or being drained this cycle
	assign out_load = (state_q == pve_pkg::ST_DONE) && (!m_tvalid || m_tready);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pve_pkg::ST_IDLE;
			head_q   <= '0;
			fill_q   <= '0;
			base_q   <= '0;
			i_q      <= '0;
			start_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				pve_pkg::ST_IDLE: begin
					if (s_acc) begin
						head_q  <= head_new;
						fill_q  <= fill_new;
						base_q  <= base_wide[IW-1:0];
						i_q     <= fill_new - 1'b1;
						start_q <= '0;
						state_q <= (fill_new < FW'(2)) ? pve_pkg::ST_DONE : pve_pkg::ST_RD;
					end
				end
				pve_pkg::ST_RD: state_q <= pve_pkg::ST_CMP;
				pve_pkg::ST_CMP: begin
					if (age > TW'(window_q)) begin
						start_q <= i_q;
						state_q <= pve_pkg::ST_OLD_RD;
					end else if (i_q == FW'(1)) begin
						state_q <= pve_pkg::ST_OLD_RD;
					end else begin
						i_q     <= i_q - 1'b1;
						state_q <= pve_pkg::ST_RD;
					end
				end
				pve_pkg::ST_OLD_RD: state_q <= pve_pkg::ST_OLD;
				pve_pkg::ST_OLD:    state_q <= pve_pkg::ST_DIVGO;
				pve_pkg::ST_DIVGO:  state_q <= pve_pkg::ST_DIV;
				pve_pkg::ST_DIV: begin
					if (!busy_x && !busy_y) begin
						state_q <= pve_pkg::ST_SAT;
					end
				end
				pve_pkg::ST_SAT: state_q <= pve_pkg::ST_DONE;
				pve_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= pve_pkg::ST_IDLE;
					end
				end
				default: state_q <= pve_pkg::ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			t_q      <= s_tdata[TW-1:0];
			x_q      <= s_tdata[TW+PW-1:TW];
			y_q      <= s_tdata[EW-1:TW+PW];
			vx_q     <= '0;
			vy_q     <= '0;
			vvalid_q <= 1'b0;
		end
		if (state_q == pve_pkg::ST_OLD) begin
			px_s1 <= pve_pkg::ProdW'(dx * signed'({1'b0, units_q}));
			py_s1 <= pve_pkg::ProdW'(dy * signed'({1'b0, units_q}));
			dur_q <= (age == '0) ? TW'(1) : age;
		end
		if (state_q == pve_pkg::ST_SAT) begin
			vx_q     <= sat_f(px_s1[pve_pkg::ProdW-1], qx, maxv_q);
			vy_q     <= sat_f(py_s1[pve_pkg::ProdW-1], qy, maxv_q);
			vvalid_q <= 1'b1;
		end
		if (out_load) begin
			m_tdata <= {vy_q, vx_q};
			m_tuser <= {vvalid_q, pve_pkg::CountW'(fill_q)};
		end
	end

	// ---------------- assertions ----------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(HISTORY_DEPTH))
		else $error("fill count beyond depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < IW'(HISTORY_DEPTH))
		else $error("head pointer beyond depth");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pve_pkg::ST_RD |-> (i_q >= FW'(1) && i_q < fill_q))
		else $error("scan position out of range");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pve_pkg::ST_DIVGO |=> (busy_x && busy_y))
		else $error("dividers did not start");

endmodule
